@@ src/mbls_pkg.sv @@
`default_nettype none
package mbls_pkg;

   // Input commands.
   localparam logic [1:0] CMD_DATA = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_EOS  = 2'd2;

   // Result kinds.
   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_LINE_END = 3'd1;
   localparam logic [2:0] KIND_PART     = 3'd2;
   localparam logic [2:0] KIND_FINAL    = 3'd3;
   localparam logic [2:0] KIND_EOS      = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_LENGTH = 1'b1;

   // Characters.
   localparam logic [7:0] CH_DASH = 8'h2d;
   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [7:0] CH_LF   = 8'h0a;
   localparam logic [7:0] POS_MAX = 8'hff;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      OP_DATA,
      OP_LINE_END,
      OP_EOS,
      OP_LOAD
   } op_code_type;

   // One operation handed from the front end to the back end.
   typedef struct packed {
      op_code_type code;
      logic [7:0]  data;
      logic [6:0]  index;
      logic        last;
   } op_type;

endpackage
`default_nettype wire

@@ src/mbls_ram.sv @@
`default_nettype none
module mbls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/mbls_queue.sv @@
`default_nettype none
module mbls_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire mbls_pkg::op_type push_op,
   output logic                 full,
   input  wire logic            pop,
   output logic                 head_valid,
   output mbls_pkg::op_type     head_op
);
   import mbls_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   op_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

@@ src/mbls_front.sv @@
`default_nettype none
module mbls_front #(
   parameter int MAX_BOUNDARY = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [6:0] req_load_index,
   output logic            push,
   output mbls_pkg::op_type push_op,
   input  wire logic       full
);
   import mbls_pkg::*;

   localparam logic [7:0] MAX_B = 8'(MAX_BOUNDARY);

   logic       pending_cr_ff, pending_cr_in;
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       accept;

   // While the second beat of a CR pair waits, no new item is taken.
   assign req_ready = !full && !hold_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pending_cr_in = pending_cr_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      push          = 1'b0;
      push_op.code  = OP_DATA;
      push_op.data  = req_data_byte;
      push_op.index = req_load_index;
      push_op.last  = 1'b1;
      if (hold_valid_ff) begin
         push         = 1'b1;
         push_op.data = hold_byte_ff;
         if (!full) begin
            hold_valid_in = 1'b0;
         end
      end else if (accept) begin
         unique case (req_cmd)
            CMD_DATA: begin
               if (pending_cr_ff) begin
                  pending_cr_in = 1'b0;
                  push          = 1'b1;
                  if (req_data_byte == CH_LF) begin
                     push_op.code = OP_LINE_END;
                  end else begin
                     // The held CR turns into data; an ordinary byte follows it, while a second CR is held in turn.
                     push_op.data = CH_CR;
                     if (req_data_byte == CH_CR) begin
                        pending_cr_in = 1'b1;
                     end else begin
                        push_op.last  = 1'b0;
                        hold_valid_in = 1'b1;
                        hold_byte_in  = req_data_byte;
                     end
                  end
               end else if (req_data_byte == CH_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  push = 1'b1;
                  if (req_data_byte == CH_LF) begin
                     push_op.code = OP_LINE_END;
                  end
               end
            end
            CMD_LOAD: begin
               push_op.code = OP_LOAD;
               push         = ({1'b0, req_load_index} < MAX_B);
            end
            CMD_EOS: begin
               pending_cr_in = 1'b0;
               push          = 1'b1;
               push_op.code  = OP_EOS;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_cr_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         pending_cr_ff <= pending_cr_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_byte_ff <= hold_byte_in;
   end

endmodule
`default_nettype wire

@@ src/mbls_back.sv @@
`default_nettype none
module mbls_back #(
   parameter int MAX_BOUNDARY = 128
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire mbls_pkg::op_type head_op,
   output logic                  pop,
   input  wire logic             boundary_enable,
   input  wire logic [7:0]       boundary_text_length,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [2:0]       rsp_kind,
   output logic      [7:0]       rsp_out_byte,
   output logic      [31:0]      rsp_line_number,
   output logic                  rsp_line_had_data,
   output logic                  rsp_last_part_seen,
   output logic                  rsp_last
);
   import mbls_pkg::*;

   localparam int AW = $clog2(MAX_BOUNDARY);
   localparam logic [7:0] MAX_B = 8'(MAX_BOUNDARY);

   typedef struct packed {
      op_code_type code;
      logic [7:0]  data;
      logic        last;
      logic        sel_dash;
      logic        sel_text;
      logic        is_part;
      logic        is_final;
      logic        had;
   } compare_type;

   // Address stage.
   logic [7:0]  pos_ff, pos_in;
   logic [8:0]  pos9, len9;
   logic [7:0]  text_idx;
   logic        in_lead, in_text, in_tail, text_ok;
   logic        rd_en, wr_en;
   logic [7:0]  rd_data;

   // Compare stage.
   compare_type cmp_ff, cmp_in;
   logic        cmp_valid_ff, cmp_valid_in;
   logic        cmp_adv, fit;

   // Line state and result register.
   logic        matches_ff, matches_in;
   logic [31:0] line_number_ff, line_number_in;
   logic        final_ff, final_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff, kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [31:0] out_line_ff, out_line_in;
   logic        had_ff, had_in;
   logic        seen_ff, seen_in;
   logic        last_ff, last_in;

   assign cmp_adv = cmp_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop     = head_valid && (!cmp_valid_ff || cmp_adv);

   assign pos9     = {1'b0, pos_ff};
   assign len9     = {1'b0, boundary_text_length};
   assign text_idx = pos_ff - 8'd2;
   assign in_lead  = (pos_ff < 8'd2);
   assign in_text  = !in_lead && (pos9 < len9 + 9'd2);
   assign in_tail  = !in_lead && !in_text && (pos9 < len9 + 9'd4);
   assign text_ok  = (text_idx < MAX_B);
   assign rd_en    = pop && (head_op.code == OP_DATA) && in_text && text_ok;
   assign wr_en    = pop && (head_op.code == OP_LOAD);

   mbls_ram #(
      .WIDTH(8),
      .DEPTH(MAX_BOUNDARY)
   ) u_text_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(head_op.index)),
      .wr_data(head_op.data),
      .rd_en  (rd_en),
      .rd_addr(AW'(text_idx)),
      .rd_data(rd_data)
   );

   always_comb begin
      pos_in          = pos_ff;
      cmp_in.code     = head_op.code;
      cmp_in.data     = head_op.data;
      cmp_in.last     = head_op.last;
      cmp_in.sel_dash = in_lead || in_tail;
      cmp_in.sel_text = in_text && text_ok;
      cmp_in.is_part  = (pos9 == len9 + 9'd2);
      cmp_in.is_final = (pos9 == len9 + 9'd4);
      cmp_in.had      = (pos_ff != 8'd0);
      cmp_valid_in    = cmp_valid_ff;
      if (pop) begin
         cmp_valid_in = (head_op.code != OP_LOAD);
         case (head_op.code)
            OP_DATA:     pos_in = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 8'd1;
            OP_LINE_END: pos_in = 8'd0;
            OP_EOS:      pos_in = 8'd0;
            default:     pos_in = pos_ff;
         endcase
      end else if (cmp_adv) begin
         cmp_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (cmp_ff.sel_dash) begin
         fit = (cmp_ff.data == CH_DASH);
      end else if (cmp_ff.sel_text) begin
         fit = (rd_data == cmp_ff.data);
      end else begin
         fit = 1'b0;
      end
   end

   always_comb begin
      matches_in     = matches_ff;
      line_number_in = line_number_ff;
      final_in       = final_ff;
      kind_in        = kind_ff;
      out_byte_in    = out_byte_ff;
      out_line_in    = out_line_ff;
      had_in         = had_ff;
      seen_in        = seen_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (cmp_adv) begin
         rsp_valid_in = 1'b1;
         last_in      = cmp_ff.last;
         had_in       = 1'b0;
         case (cmp_ff.code)
            OP_DATA: begin
               matches_in  = matches_ff && fit;
               kind_in     = KIND_DATA;
               out_byte_in = cmp_ff.data;
            end
            OP_LINE_END: begin
               line_number_in = line_number_ff + 32'd1;
               matches_in     = 1'b1;
               kind_in        = KIND_LINE_END;
               out_byte_in    = CH_LF;
               if (boundary_enable && matches_ff) begin
                  if (cmp_ff.is_part) begin
                     kind_in = KIND_PART;
                  end else if (cmp_ff.is_final) begin
                     kind_in  = KIND_FINAL;
                     final_in = 1'b1;
                  end
               end
            end
            default: begin
               matches_in  = 1'b1;
               kind_in     = KIND_EOS;
               out_byte_in = 8'd0;
               had_in      = cmp_ff.had;
            end
         endcase
         out_line_in = line_number_in;
         seen_in     = final_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= 8'd0;
         cmp_valid_ff   <= 1'b0;
         matches_ff     <= 1'b1;
         line_number_ff <= 32'd1;
         final_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         cmp_valid_ff   <= cmp_valid_in;
         matches_ff     <= matches_in;
         line_number_ff <= line_number_in;
         final_ff       <= final_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmp_ff      <= pop ? cmp_in : cmp_ff;
      kind_ff     <= kind_in;
      out_byte_ff <= out_byte_in;
      out_line_ff <= out_line_in;
      had_ff      <= had_in;
      seen_ff     <= seen_in;
      last_ff     <= last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_line_number    = out_line_ff;
   assign rsp_line_had_data  = had_ff;
   assign rsp_last_part_seen = seen_ff;
   assign rsp_last           = last_ff;

endmodule
`default_nettype wire

@@ src/mime_boundary_line_splitter.sv @@
`default_nettype none
// MIME multipart boundary line splitter. Body bytes come in on the req_ channel and
// leave on the rsp_ channel as data beats and line-end beats; every line is matched
// on the fly against "--" plus the boundary text loaded through cmd 1, and its line-end
// beat says whether it was an ordinary line, a part boundary, or the final boundary
// (which also raises the sticky last-part flag). A CR directly before an LF is
// swallowed, a CR before any other byte comes out as data, and end of stream drops a
// held CR and reports whether the open line had bytes. The block takes one item per
// clock while the queue is not full; the one exception is a held CR followed by an
// ordinary byte, which makes two beats and holds off the next item until the second
// is pushed, since the front end feeds one operation per clock into the queue. A taken
// item passes through the operation queue, then the compare stage, which holds the
// boundary text memory's registered read, and then the output register. The queue
// and the output register let input and output stall independently.
// Configuration writes are taken on every clock and must only happen while the block
// is idle.
module mime_boundary_line_splitter #(
   parameter int MAX_BOUNDARY = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [6:0]  req_load_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [2:0]  rsp_kind,
   output logic      [7:0]  rsp_out_byte,
   output logic      [31:0] rsp_line_number,
   output logic             rsp_line_had_data,
   output logic             rsp_last_part_seen,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import mbls_pkg::*;

   // Configuration registers.
   logic       enable_ff, enable_in;
   logic [7:0] length_ff, length_in;

   // Front end to queue, queue to back end.
   logic   push, full, pop, head_valid;
   op_type push_op, head_op;

   // The register file has no wait states.
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      length_in = length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE: enable_in = csr_data[0];
            CSR_LENGTH: length_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         length_ff <= 8'd0;
      end else begin
         enable_ff <= enable_in;
         length_ff <= length_in;
      end
   end

   // The front end resolves CR handling and decodes commands into operations.
   mbls_front #(
      .MAX_BOUNDARY(MAX_BOUNDARY)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_load_index(req_load_index),
      .push          (push),
      .push_op       (push_op),
      .full          (full)
   );

   // A short queue decouples the decoder from the matcher.
   mbls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_op   (head_op)
   );

   // The back end tracks line position, matches against the stored text and
   // produces the result beats.
   mbls_back #(
      .MAX_BOUNDARY(MAX_BOUNDARY)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_op             (head_op),
      .pop                 (pop),
      .boundary_enable     (enable_ff),
      .boundary_text_length(length_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_line_number     (rsp_line_number),
      .rsp_line_had_data   (rsp_line_had_data),
      .rsp_last_part_seen  (rsp_last_part_seen),
      .rsp_last            (rsp_last)
   );

endmodule
`default_nettype wire

@@ verif/mime_boundary_line_splitter_tb.sv @@
`timescale 1ns / 1ps
module mime_boundary_line_splitter_tb;
   import mbls_pkg::*;

   // The fourth command code has no meaning and the block must drop it silently.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int BOUNDARY_DEPTH = 128;
   // Cycles to let a beat that makes no result drain through the pipeline.
   localparam int SETTLE_CYCLES = 8;
   // The long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 2000000;

   // One input beat as the sender offers it.
   typedef struct {
      logic [1:0] cmd;
      logic [7:0] data_byte;
      logic [6:0] load_index;
   } body_item_type;

   // One output beat as the predictor expects it.
   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [31:0] line_number;
      logic        had_data;
      logic        part_flag;
      logic        last;
   } line_beat_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_DATA;
   logic [7:0]  req_data_byte = 8'd0;
   logic [6:0]  req_load_index = 7'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_line_number;
   logic        rsp_line_had_data;
   logic        rsp_last_part_seen;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_ENABLE;
   logic [7:0]  csr_data = 8'd0;

   mime_boundary_line_splitter #(
      .MAX_BOUNDARY(BOUNDARY_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_data_byte(req_data_byte),
      .req_load_index(req_load_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_line_number(rsp_line_number),
      .rsp_line_had_data(rsp_line_had_data),
      .rsp_last_part_seen(rsp_last_part_seen),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Beats waiting to be offered, and the beats the block still owes us.
   body_item_type pending_items[$];
   line_beat_type expected_beats[$];

   int issued_count = 0;
   int accepted_count = 0;
   int phase_items = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   // Idling controls. The stimulus process changes them between phases so that some
   // phases run with back-to-back beats on one or both sides.
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_requests = 0;
   int hold_served = 0;

   // The sender's copy of the boundary text, used to build matching lines.
   logic [7:0] text_copy [0:BOUNDARY_DEPTH-1];

   // ------------------------------------------------------------------------------
   // Predictor. This is an independent copy of the splitter's state: the two
   // configuration registers, the held CR, the position and match status of the open
   // line, the line counter, the sticky final flag and the boundary text store.
   // ------------------------------------------------------------------------------
   logic        bnd_enable;
   logic [7:0]  bnd_length;
   logic        cr_held;
   logic [7:0]  line_pos;
   logic        line_ok;
   logic [31:0] line_count;
   logic        final_flag;
   logic [7:0]  text_mem [0:BOUNDARY_DEPTH-1];

   function automatic void reset_predictor();
      bnd_enable = 1'b0;
      bnd_length = 8'd0;
      cr_held = 1'b0;
      line_pos = 8'd0;
      line_ok = 1'b1;
      line_count = 32'd1;
      final_flag = 1'b0;
   endfunction

   // A line matches while every byte so far fits "--", then the text, then "--".
   // Text positions beyond the store never match.
   function automatic bit char_fits(input int unsigned pos, input logic [7:0] ch);
      int unsigned len;
      len = bnd_length;
      if (pos < 2)
         return ch == CH_DASH;
      if (pos < 2 + len) begin
         if (pos - 2 >= BOUNDARY_DEPTH)
            return 1'b0;
         return text_mem[pos - 2] == ch;
      end
      if (pos < len + 4)
         return ch == CH_DASH;
      return 1'b0;
   endfunction

   function automatic void expect_beat(input logic [2:0] kind, input logic [7:0] value,
                                       input logic had);
      line_beat_type beat;
      beat.kind = kind;
      beat.out_byte = value;
      beat.line_number = line_count;
      beat.had_data = had;
      beat.part_flag = final_flag;
      beat.last = 1'b0;
      expected_beats.push_back(beat);
   endfunction

   function automatic void take_line_byte(input logic [7:0] ch);
      if (!char_fits(line_pos, ch))
         line_ok = 1'b0;
      if (line_pos != POS_MAX)
         line_pos = line_pos + 8'd1;
      expect_beat(KIND_DATA, ch, 1'b0);
   endfunction

   // An LF closes the line. Its beat tells whether the whole line was the part or
   // the final boundary; the final one also raises the sticky flag.
   function automatic void close_line();
      logic [2:0] kind;
      kind = KIND_LINE_END;
      line_count = line_count + 32'd1;
      if (bnd_enable && line_ok) begin
         if (int'(line_pos) == int'(bnd_length) + 2) begin
            kind = KIND_PART;
         end else if (int'(line_pos) == int'(bnd_length) + 4) begin
            kind = KIND_FINAL;
            final_flag = 1'b1;
         end
      end
      line_pos = 8'd0;
      line_ok = 1'b1;
      expect_beat(kind, CH_LF, 1'b0);
   endfunction

   function automatic void take_plain_byte(input logic [7:0] ch);
      if (ch == CH_CR)
         cr_held = 1'b1;
      else if (ch == CH_LF)
         close_line();
      else
         take_line_byte(ch);
   endfunction

   // Works out the beats that one accepted input beat causes and marks the last one.
   function automatic void split_item(input logic [1:0] cmd, input logic [7:0] value,
                                      input logic [6:0] index);
      int before_count;
      line_beat_type beat;
      before_count = expected_beats.size();
      case (cmd)
         CMD_DATA: begin
            if (cr_held) begin
               // A held CR vanishes before an LF and turns into data otherwise.
               cr_held = 1'b0;
               if (value == CH_LF) begin
                  close_line();
               end else begin
                  take_line_byte(CH_CR);
                  take_plain_byte(value);
               end
            end else begin
               take_plain_byte(value);
            end
         end
         CMD_LOAD: begin
            if (index < BOUNDARY_DEPTH)
               text_mem[index] = value;
         end
         CMD_EOS: begin
            // A held CR is dropped; the counter and the final flag survive.
            cr_held = 1'b0;
            expect_beat(KIND_EOS, 8'd0, line_pos != 8'd0);
            line_pos = 8'd0;
            line_ok = 1'b1;
         end
         default: begin
         end
      endcase
      if (expected_beats.size() > before_count) begin
         beat = expected_beats.pop_back();
         beat.last = 1'b1;
         expected_beats.push_back(beat);
      end
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_beat();
      line_beat_type want;
      if (expected_beats.size() == 0) begin
         $error("result beat with nothing expected: kind %0d out_byte %0h",
                rsp_kind, rsp_out_byte);
         mismatch_count++;
      end else begin
         want = expected_beats.pop_front();
         compare_field("kind", want.kind, rsp_kind);
         compare_field("out_byte", want.out_byte, rsp_out_byte);
         compare_field("line_number", want.line_number, rsp_line_number);
         compare_field("line_had_data", want.had_data, rsp_line_had_data);
         compare_field("last_part_seen", want.part_flag, rsp_last_part_seen);
         compare_field("last", want.last, rsp_last);
      end
   endfunction

   // ------------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, where the inputs are stable
   // because they only change at the falling edge. A result beat is checked before
   // the input beat of the same edge is predicted, since a result always belongs to
   // an earlier input beat.
   // ------------------------------------------------------------------------------
   logic req_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: bnd_enable = csr_data[0];
               CSR_LENGTH: bnd_length = csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready)
            check_beat();
         if (req_valid && req_ready) begin
            split_item(req_cmd, req_data_byte, req_load_index);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Idle lengths: mostly none or a few cycles, now and then a long one.
   function automatic int pick_delay();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   // ------------------------------------------------------------------------------
   // Driver. A beat stays on the bus, unchanged, until the edge that takes it. Only
   // then may a gap follow or the next beat come up, so valid gets a single update
   // per falling edge.
   // ------------------------------------------------------------------------------
   int req_gap_left = 0;

   always @(negedge clock) begin
      body_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Still waiting for the block to take the current beat.
      end else if (req_gap_left > 0) begin
         req_gap_left--;
         req_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
         item = pending_items.pop_front();
         req_cmd <= item.cmd;
         req_data_byte <= item.data_byte;
         req_load_index <= item.load_index;
         req_valid <= 1'b1;
         req_gap_left = req_gaps_on ? pick_delay() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver. Short random stalls, plus one long hold-off on request while the
   // sender keeps pushing, so the queue inside the block fills and req_ready drops.
   int rsp_stall_left = 0;
   int rsp_hold_left = 0;

   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_requests != hold_served) begin
         hold_served++;
         rsp_hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls_on)
            rsp_stall_left = pick_delay();
      end
   end

   // ------------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------------
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] value,
                            input logic [6:0] index);
      body_item_type item;
      item.cmd = cmd;
      item.data_byte = value;
      item.load_index = index;
      pending_items.push_back(item);
      issued_count++;
      phase_items++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_item(CMD_DATA, value, 7'($urandom_range(0, 127)));
   endtask

   // Boundary characters never contain CR or LF, so a well-formed boundary line
   // reaches the block byte for byte. Dashes inside the text are common.
   function automatic logic [7:0] rand_text_char();
      logic [7:0] ch;
      if ($urandom_range(0, 9) == 0)
         return CH_DASH;
      do
         ch = 8'($urandom_range(0, 255));
      while (ch == CH_CR || ch == CH_LF);
      return ch;
   endfunction

   // Free body bytes lean toward CR so that lone CRs, CR pairs and CR before data
   // all show up, and toward dashes so that near misses of the boundary are common.
   function automatic logic [7:0] rand_body_byte();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return CH_CR;
      if (r < 12)
         return CH_LF;
      if (r < 20)
         return CH_DASH;
      return 8'($urandom_range(0, 255));
   endfunction

   // A load in the middle of a line. Every entry was written during setup, so any
   // index is safe. Usually the same character is written back, which keeps the
   // boundary intact; otherwise the sender's copy follows the change.
   task automatic reload_text_char();
      logic [6:0] index;
      index = 7'($urandom_range(0, BOUNDARY_DEPTH - 1));
      if ($urandom_range(0, 2) == 0)
         text_copy[index] = rand_text_char();
      send_item(CMD_LOAD, text_copy[index], index);
   endtask

   // One line: an exact part boundary, a final boundary, a near miss of either, or
   // noise, and then a line end, sometimes an end of stream instead.
   task automatic gen_line(input int unsigned len);
      logic [7:0] chars [0:511];
      int unsigned n;
      int unsigned r;
      int unsigned k;
      r = $urandom_range(0, 99);
      n = 0;
      if (r < 60) begin
         chars[0] = CH_DASH;
         chars[1] = CH_DASH;
         n = 2;
         for (k = 0; k < len; k++) begin
            chars[n] = (k < BOUNDARY_DEPTH) ? text_copy[k] : rand_text_char();
            n++;
         end
         if (r >= 30 && r < 45) begin
            chars[n] = CH_DASH;
            chars[n + 1] = CH_DASH;
            n = n + 2;
         end else if (r >= 45) begin
            case ($urandom_range(0, 3))
               0: begin
                  k = $urandom_range(0, n - 1);
                  chars[k] = chars[k] ^ (8'h01 << $urandom_range(0, 7));
               end
               1: n--;
               2: begin
                  chars[n] = rand_text_char();
                  n++;
               end
               default: begin
                  chars[n] = CH_DASH;
                  chars[n + 1] = CH_DASH;
                  chars[n + 2] = CH_DASH;
                  n = n + 3;
               end
            endcase
         end
      end else begin
         n = ($urandom_range(0, 99) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 20);
         for (k = 0; k < n; k++)
            chars[k] = rand_body_byte();
      end
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 49) == 0)
            reload_text_char();
         send_byte(chars[k]);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         send_byte(CH_CR);
         send_item(CMD_EOS, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      end else if (r < 6) begin
         send_item(CMD_EOS, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      end else begin
         if (r < 9)
            send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
         if (r < 60)
            send_byte(CH_CR);
         send_byte(CH_LF);
      end
   endtask

   // The block counts as idle once every offered beat was taken and every expected
   // result came back. A load makes no result, so a few cycles more let it settle.
   task automatic wait_idle();
      while (accepted_count != issued_count || expected_beats.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic enable, input logic [7:0] len);
      wait_idle();
      write_csr(CSR_ENABLE, {7'd0, enable});
      write_csr(CSR_LENGTH, len);
   endtask

   // ------------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------------
   initial begin
      int phase;
      int k;
      int load_count;
      logic enable;
      logic [7:0] len;

      reset_predictor();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Fill the whole text store once, so that no later line can ever compare
      // against an entry that was never written, whatever length is set.
      configure(1'b1, 8'd2);
      for (k = 0; k < BOUNDARY_DEPTH; k++) begin
         text_copy[k] = rand_text_char();
         send_item(CMD_LOAD, text_copy[k], 7'(k));
      end

      // Directed beats with a two-character boundary. First the byte extremes on an
      // ordinary line, then an exact part boundary and a final boundary closed by
      // CR LF.
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(CH_LF);
      send_byte(CH_DASH);
      send_byte(CH_DASH);
      send_byte(text_copy[0]);
      send_byte(text_copy[1]);
      send_byte(CH_LF);
      send_byte(CH_DASH);
      send_byte(CH_DASH);
      send_byte(text_copy[0]);
      send_byte(text_copy[1]);
      send_byte(CH_DASH);
      send_byte(CH_DASH);
      send_byte(CH_CR);
      send_byte(CH_LF);
      // A CR before ordinary data comes out as data, and of two CRs in a row the
      // first is data while the second waits and then disappears before the LF.
      send_byte(CH_CR);
      send_byte(8'h61);
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_byte(CH_LF);
      // End of stream drops a held CR, which leaves the open line without data, and a
      // second one reports an empty line too. The unused command must leave no trace.
      send_byte(CH_CR);
      send_item(CMD_EOS, 8'hff, 7'h7f);
      send_item(CMD_EOS, 8'h00, 7'h00);
      send_item(CMD_UNUSED, 8'h5a, 7'h2a);

      // Random phases. Each one picks a register setting, loads a fresh boundary
      // text of that length and then streams mostly well-formed boundary lines with
      // noise mixed in. Lengths cover zero, the full store and beyond it, where no
      // line may match, and one phase runs with matching switched off.
      for (phase = 0; phase < 10; phase++) begin
         req_gaps_on = 1'b1;
         rsp_stalls_on = 1'b1;
         enable = 1'b1;
         len = 8'($urandom_range(1, 8));
         case (phase)
            1: len = 8'd0;
            2: len = 8'(BOUNDARY_DEPTH);
            3: enable = 1'b0;
            4: len = 8'd255;
            5: begin
               len = 8'($urandom_range(1, 16));
               req_gaps_on = 1'b0;
            end
            6: len = 8'd1;
            7: begin
               len = 8'($urandom_range(0, 40));
               req_gaps_on = 1'b0;
               rsp_stalls_on = 1'b0;
            end
            8: len = 8'd200;
            default: begin
            end
         endcase
         configure(enable, len);
         load_count = (len > BOUNDARY_DEPTH) ? BOUNDARY_DEPTH : int'(len);
         for (k = 0; k < load_count; k++) begin
            text_copy[k] = rand_text_char();
            send_item(CMD_LOAD, text_copy[k], 7'(k));
         end
         // Hold the receiver off while a gapless sender keeps offering beats.
         if (phase == 5)
            hold_requests++;
         // One line long enough to saturate the position counter.
         if (phase == 6) begin
            for (k = 0; k < 262; k++)
               send_byte(rand_text_char());
            send_byte(CH_LF);
         end
         phase_items = 0;
         while (phase_items < 110)
            gen_line(len);
      end

      wait_idle();
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
